// ===== hw/rtl/swhsr_pkg.sv =====
package swhsr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_RELEASE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_RESP_END,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_GAP
    } t_phase;

    localparam logic [2:0] CFG_THRESH  = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_START   = 3'd2;
    localparam logic [2:0] CFG_RELEASE = 3'd3;
    localparam logic [2:0] CFG_GAP     = 3'd4;
    localparam logic [2:0] CFG_TRIES   = 3'd5;
    localparam logic [2:0] CFG_HMAX    = 3'd6;
    localparam logic [2:0] CFG_TMAX    = 3'd7;

    localparam logic [1:0] FAIL_NONE   = 2'd0;
    localparam logic [1:0] FAIL_NORESP = 2'd1;
    localparam logic [1:0] FAIL_SUM    = 2'd2;
    localparam logic [1:0] FAIL_RANGE  = 2'd3;

    // Queue entry from the front (line sequencer) to the back (history/output).
    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       fail_done;
        logic [1:0] fail_reason;
        logic [9:0] hum;
        logic [8:0] temp;
    } t_evt;

endpackage

// ===== hw/rtl/swhsr_front.sv =====
module swhsr_front
    import swhsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_line,
    input  logic        i_start,
    output logic        o_valid,
    input  logic        i_ready,
    output t_evt        o_evt
);

    logic [7:0]  r_thresh;
    logic [9:0]  r_timeout, r_release;
    logic [19:0] r_start_low, r_gap;
    logic [2:0]  r_tries;
    logic [10:0] r_hmax;
    logic [9:0]  r_tmax;

    t_phase      r_phase, n_phase;
    logic [19:0] r_cnt, n_cnt;
    logic [5:0]  r_bidx, n_bidx;
    logic [39:0] r_frame, n_frame;
    logic [2:0]  r_try, n_try;
    logic [1:0]  r_fail, n_fail;
    t_evt        r_evt;
    logic        r_vld;

    logic        acc;
    logic        push, pbit;
    logic        fdone, fok;
    logic [19:0] cnt_inc;
    logic [2:0]  tries;
    logic [7:0]  d0, d1, d2, d3, d4, sum8;
    logic [11:0] h, t;
    logic [9:0]  hs;
    logic [8:0]  ts;
    logic [39:0] fr_new;
    logic [5:0]  bi_new;

    assign o_ready = !r_vld || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_evt   = r_evt;
    assign cnt_inc = r_cnt + 20'd1;
    assign tries   = (r_tries == 3'd0) ? 3'd1 : r_tries;

    assign fr_new = {r_frame[38:0], pbit};
    assign bi_new = r_bidx + 6'd1;
    assign d0 = fr_new[39:32];
    assign d1 = fr_new[31:24];
    assign d2 = fr_new[23:16];
    assign d3 = fr_new[15:8];
    assign d4 = fr_new[7:0];
    assign sum8 = d0 + d1 + d2 + d3;
    // x*10 as (x<<3)+(x<<1), narrow enough to stay combinational.
    assign h = ({4'd0, d0} << 3) + ({4'd0, d0} << 1) + {4'd0, d1};
    assign t = ({4'd0, d2} << 3) + ({4'd0, d2} << 1) + {4'd0, d3};
    assign hs = (h > 12'd1023) ? 10'd1023 : h[9:0];
    assign ts = (t > 12'd511) ? 9'd511 : t[8:0];

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_bidx  = r_bidx;
        n_frame = r_frame;
        n_try   = r_try;
        n_fail  = r_fail;
        push    = 1'b0;
        pbit    = 1'b0;
        fdone   = 1'b0;
        fok     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_try = 3'd0; n_fail = FAIL_NONE;
                    n_phase = PH_START; n_cnt = 20'd1; n_bidx = '0; n_frame = '0;
                end
            end
            PH_START: begin
                if (r_cnt >= r_start_low) begin
                    n_phase = PH_RELEASE; n_cnt = 20'd1;
                end else n_cnt = cnt_inc;
            end
            PH_RELEASE: begin
                if (r_cnt >= {10'd0, r_release}) begin
                    n_phase = PH_RESP_LOW; n_cnt = '0;
                end else n_cnt = cnt_inc;
            end
            PH_RESP_LOW, PH_RESP_END: begin
                if (!i_line) begin
                    n_phase = (r_phase == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_LOW;
                    n_cnt = 20'd1;
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc > {10'd0, r_timeout}) begin
                        n_fail = FAIL_NORESP; n_phase = PH_GAP; n_cnt = '0;
                    end
                end
            end
            PH_RESP_HIGH: begin
                if (i_line) begin
                    n_phase = PH_RESP_END; n_cnt = 20'd1;
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc > {10'd0, r_timeout}) begin
                        n_fail = FAIL_NORESP; n_phase = PH_GAP; n_cnt = '0;
                    end
                end
            end
            PH_BIT_LOW: begin
                if (i_line) begin
                    n_phase = PH_BIT_HIGH; n_cnt = 20'd1;
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc > {10'd0, r_timeout}) begin
                        n_cnt = '0; push = 1'b1;
                    end
                end
            end
            PH_BIT_HIGH: begin
                if (!i_line) begin
                    pbit = r_cnt > {12'd0, r_thresh};
                    n_phase = PH_BIT_LOW; n_cnt = 20'd1; push = 1'b1;
                end else begin
                    n_cnt = cnt_inc;
                    if (cnt_inc > {10'd0, r_timeout}) begin
                        n_phase = PH_BIT_LOW; n_cnt = '0; push = 1'b1;
                    end
                end
            end
            PH_GAP: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= r_gap) begin
                    if (r_try < 3'd7) n_try = r_try + 3'd1;
                    if (((r_try < 3'd7) ? r_try + 3'd1 : r_try) >= tries) begin
                        n_phase = PH_IDLE; n_cnt = '0; fdone = 1'b1;
                    end else begin
                        n_phase = PH_START; n_cnt = 20'd1; n_bidx = '0; n_frame = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE; n_cnt = '0;
            end
        endcase
        if (push) begin
            n_frame = fr_new;
            n_bidx  = bi_new;
            if (bi_new >= 6'd40) begin
                if (sum8 != d4) begin
                    n_fail = FAIL_SUM; n_phase = PH_GAP; n_cnt = '0;
                end else if (h > {1'b0, r_hmax} || t > {2'b0, r_tmax}) begin
                    n_fail = FAIL_RANGE; n_phase = PH_GAP; n_cnt = '0;
                end else begin
                    n_fail = FAIL_NONE; n_phase = PH_IDLE; fok = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 8'd50; r_timeout <= 10'd100; r_start_low <= 20'd20000;
            r_release <= 10'd30; r_gap <= 20'd100000; r_tries <= 3'd3;
            r_hmax <= 11'd1000; r_tmax <= 10'd500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESH:  r_thresh    <= i_cfg_data[7:0];
                CFG_TIMEOUT: r_timeout   <= i_cfg_data[9:0];
                CFG_START:   r_start_low <= i_cfg_data;
                CFG_RELEASE: r_release   <= i_cfg_data[9:0];
                CFG_GAP:     r_gap       <= i_cfg_data;
                CFG_TRIES:   r_tries     <= i_cfg_data[2:0];
                CFG_HMAX:    r_hmax      <= i_cfg_data[10:0];
                CFG_TMAX:    r_tmax      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_cnt <= '0; r_bidx <= '0; r_frame <= '0;
            r_try <= '0; r_fail <= FAIL_NONE; r_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase; r_cnt <= n_cnt; r_bidx <= n_bidx;
                r_frame <= n_frame; r_try <= n_try; r_fail <= n_fail;
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_evt.drive_low   <= n_phase == PH_START;
            r_evt.busy        <= n_phase != PH_IDLE;
            r_evt.done        <= fok;
            r_evt.fail_done   <= fdone;
            r_evt.fail_reason <= n_fail;
            r_evt.hum         <= hs;
            r_evt.temp        <= ts;
        end
    end

endmodule

// ===== hw/rtl/swhsr_back.sv =====
module swhsr_back
    import swhsr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_evt       i_evt,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_drive_low,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_read_ok,
    output logic [1:0] o_fail_reason,
    output logic [9:0] o_humidity_tenths,
    output logic [8:0] o_temp_tenths,
    output logic       o_averaged
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HW = 10 + $clog2(HISTORY_DEPTH + 1);
    localparam int TW = 9 + $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [HW-1:0] HHALF = HW'(HISTORY_DEPTH / 2);
    localparam logic [TW-1:0] THALF = TW'(HISTORY_DEPTH / 2);
    localparam int LG  = $clog2(HISTORY_DEPTH);
    localparam int HPW = 2 * HW + 1;
    localparam int TPW = 2 * TW + 1;
    localparam int HSH = HW + LG;
    localparam int TSH = TW + LG;
    localparam int HMW = HW + 1;
    localparam int TMW = TW + 1;
    // Reciprocal of the depth rounded up; the upper product bits then give the exact
    // floor quotient for every total the accumulators can hold.
    localparam logic [HMW-1:0] HMUL = HMW'((2 ** HSH + HISTORY_DEPTH - 1) / HISTORY_DEPTH);
    localparam logic [TMW-1:0] TMUL = TMW'((2 ** TSH + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

    // Stage 1 reads the old entries; stage 2 updates totals and forms the output.
    logic [9:0]    hmem [HISTORY_DEPTH];
    logic [8:0]    tmem [HISTORY_DEPTH];
    logic [9:0]    r_hold;
    logic [8:0]    r_told;
    logic [AW-1:0] r_slot;
    logic          r_full;
    logic [HW-1:0] r_htot;
    logic [TW-1:0] r_ttot;
    t_evt          r_s1;
    logic          r_v1, r_v2;
    logic          adv2, adv1;
    logic [HW-1:0] htot_n;
    logic [TW-1:0] ttot_n;
    logic          full_n;
    logic [HPW-1:0] hprod;
    logic [TPW-1:0] tprod;
    logic [9:0]    hq;
    logic [8:0]    tq;

    assign adv2    = r_v1 && (!r_v2 || i_ready);
    assign o_ready = !r_v1 || adv2;
    assign adv1    = i_valid && o_ready;
    assign o_valid = r_v2;

    // An entry read before it was first written only matters when the store is full,
    // and by then every entry has been written.
    assign htot_n = r_full ? r_htot - HW'(r_hold) + HW'(r_s1.hum) : r_htot + HW'(r_s1.hum);
    assign ttot_n = r_full ? r_ttot - TW'(r_told) + TW'(r_s1.temp) : r_ttot + TW'(r_s1.temp);
    assign full_n = r_full || (r_slot == LAST);
    assign hprod = HPW'(htot_n + HHALF) * HPW'(HMUL);
    assign tprod = TPW'(ttot_n + THALF) * TPW'(TMUL);
    assign hq = hprod[HSH +: 10];
    assign tq = tprod[TSH +: 9];

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1 <= i_evt;
        end
        if (adv1 && i_evt.done) begin
            r_hold <= hmem[r_slot + (r_v1 && r_s1.done && !adv2 ? AW'(1) : AW'(0))];
            r_told <= tmem[r_slot + (r_v1 && r_s1.done && !adv2 ? AW'(1) : AW'(0))];
        end
        if (adv2 && r_s1.done) begin
            hmem[r_slot] <= r_s1.hum;
            tmem[r_slot] <= r_s1.temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_slot <= '0; r_full <= 1'b0;
            r_htot <= '0; r_ttot <= '0;
        end else begin
            if (adv1) r_v1 <= 1'b1;
            else if (adv2) r_v1 <= 1'b0;
            if (adv2) r_v2 <= 1'b1;
            else if (i_ready) r_v2 <= 1'b0;
            if (adv2 && r_s1.done) begin
                r_slot <= (r_slot == LAST) ? '0 : r_slot + AW'(1);
                r_full <= full_n;
                r_htot <= htot_n;
                r_ttot <= ttot_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            o_drive_low   <= r_s1.drive_low;
            o_busy_res    <= r_s1.busy;
            o_done_res    <= r_s1.done || r_s1.fail_done;
            o_read_ok     <= r_s1.done;
            o_fail_reason <= r_s1.fail_reason;
            o_averaged    <= r_s1.done && full_n;
            if (!r_s1.done) begin
                o_humidity_tenths <= '0;
                o_temp_tenths     <= '0;
            end else if (full_n) begin
                o_humidity_tenths <= hq;
                o_temp_tenths     <= tq;
            end else begin
                o_humidity_tenths <= r_s1.hum;
                o_temp_tenths     <= r_s1.temp;
            end
        end
    end

endmodule

// ===== hw/rtl/single_wire_humidity_sensor_reader.sv =====
// Single-wire humidity and temperature sensor reader. Each accepted word is one
// microsecond tick with the sampled wire level and a start request, and each tick
// returns exactly one result word with the wire drive, status and, on a successful
// finish, the reading (raw until HISTORY_DEPTH readings are stored, then the rounded
// mean). A front sequencer handles the wire protocol and a back stage keeps the
// histories: its first stage reads the old entry, its second updates the totals.
// One word is taken every clock cycle while the output is not stalled.
module single_wire_humidity_sensor_reader
    import swhsr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_line_level,
    input  logic        i_start_read,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drive_low,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_read_ok,
    output logic [1:0]  o_fail_reason,
    output logic [9:0]  o_humidity_tenths,
    output logic [8:0]  o_temp_tenths,
    output logic        o_averaged
);

    t_evt evt;
    logic evt_valid, evt_ready;

    swhsr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_line(i_line_level), .i_start(i_start_read),
        .o_valid(evt_valid), .i_ready(evt_ready), .o_evt(evt)
    );

    swhsr_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(evt_valid), .o_ready(evt_ready), .i_evt(evt),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_drive_low(o_drive_low), .o_busy_res(o_busy_res),
        .o_done_res(o_done_res), .o_read_ok(o_read_ok),
        .o_fail_reason(o_fail_reason), .o_humidity_tenths(o_humidity_tenths),
        .o_temp_tenths(o_temp_tenths), .o_averaged(o_averaged)
    );

endmodule

// ===== verif/tb_single_wire_humidity_sensor_reader.sv =====
module tb_single_wire_humidity_sensor_reader;
    import swhsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST = 8;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic       drive;
        logic       busy;
        logic       done;
        logic       ok;
        logic [1:0] fail;
        logic [9:0] hum;
        logic [8:0] temp;
        logic       avg;
    } reading_t;

    typedef struct {
        bit       ln;
        bit       st;
        bit       typed;
        reading_t want;
    } step_t;

    localparam reading_t QUIET = '0;
    localparam reading_t NORESP_DONE = '{drive: 1'b0, busy: 1'b0, done: 1'b1, ok: 1'b0,
                                         fail: FAIL_NORESP, hum: '0, temp: '0, avg: 1'b0};

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [19:0] cfg_data;
    logic        in_vld;
    logic        in_rdy;
    logic        line_lvl;
    logic        start_req;
    logic        out_vld;
    logic        out_rdy;
    reading_t    got;

    single_wire_humidity_sensor_reader #(.HISTORY_DEPTH(HIST)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_valid          (in_vld),
        .o_ready          (in_rdy),
        .i_line_level     (line_lvl),
        .i_start_read     (start_req),
        .o_valid          (out_vld),
        .i_ready          (out_rdy),
        .o_drive_low      (got.drive),
        .o_busy_res       (got.busy),
        .o_done_res       (got.done),
        .o_read_ok        (got.ok),
        .o_fail_reason    (got.fail),
        .o_humidity_tenths(got.hum),
        .o_temp_tenths    (got.temp),
        .o_averaged       (got.avg)
    );

    // Register sets in index order: threshold, timeout, start low, release,
    // retry gap, tries, humidity max, temperature max.
    int unsigned reg_sets [6][8] = '{
        '{1,    2, 1, 1,    1, 1, 1000, 500},
        '{1,    4, 0, 0,    0, 0, 2047, 1023},
        '{3,   10, 3, 2,    5, 7, 1000, 500},
        '{0,    5, 2, 4,    1, 2, 0,    0},
        '{5,    8, 1, 1,    3, 3, 999,  300},
        '{2,    1, 4, 3,    2, 3, 999,  300}
    };
    int unsigned reg_width [8] = '{8, 10, 20, 10, 20, 3, 11, 10};

    // Predictor state.
    int unsigned cfg_val [8];
    t_phase      ph;
    int unsigned tc, bidx, tries_done;
    logic [1:0]  lastf;
    logic [39:0] frame;
    int unsigned hist_h [HIST];
    int unsigned hist_t [HIST];
    int unsigned slot, tot_h, tot_t;
    bit          full;
    reading_t    res_now;

    // Stimulus planning state.
    logic [39:0] plan;
    bit          resp_fail;
    int unsigned wait_len, lo_len, hi_len;

    reading_t    readings_due [$];
    int          errors, n_ticks, n_good, n_failed, n_avg, n_checked;
    int          burst_left;
    bit          hold_req;
    int          quiet_cycles;

    function automatic void reset_model();
        cfg_val = '{50, 100, 20000, 30, 100000, 3, 1000, 500};
        ph = PH_IDLE;
        tc = 0;
        bidx = 0;
        tries_done = 0;
        lastf = FAIL_NONE;
        frame = '0;
        foreach (hist_h[i]) begin
            hist_h[i] = 0;
            hist_t[i] = 0;
        end
        slot = 0;
        full = 0;
        tot_h = 0;
        tot_t = 0;
    endfunction

    function automatic void begin_try();
        ph = PH_START;
        tc = 1;
        bidx = 0;
        frame = '0;
    endfunction

    function automatic void fail_try(logic [1:0] why);
        lastf = why;
        ph = PH_GAP;
        tc = 0;
    endfunction

    function automatic void shift_in(bit b);
        int unsigned d0, d1, d2, d3, d4, h, t;
        frame = {frame[38:0], b};
        bidx++;
        if (bidx < 40) return;
        d0 = frame[39:32];
        d1 = frame[31:24];
        d2 = frame[23:16];
        d3 = frame[15:8];
        d4 = frame[7:0];
        if (((d0 + d1 + d2 + d3) & 8'hFF) != d4) begin
            fail_try(FAIL_SUM);
            return;
        end
        h = d0 * 10 + d1;
        t = d2 * 10 + d3;
        if (h > cfg_val[CFG_HMAX] || t > cfg_val[CFG_TMAX]) begin
            fail_try(FAIL_RANGE);
            return;
        end
        if (h > 1023) h = 1023;
        if (t > 511) t = 511;
        tot_h = tot_h - hist_h[slot] + h;
        tot_t = tot_t - hist_t[slot] + t;
        hist_h[slot] = h;
        hist_t[slot] = t;
        slot = (slot + 1) % HIST;
        if (slot == 0) full = 1;
        lastf = FAIL_NONE;
        ph = PH_IDLE;
        res_now.done = 1'b1;
        res_now.ok = 1'b1;
        if (full) begin
            res_now.avg = 1'b1;
            res_now.hum = 10'((tot_h + HIST / 2) / HIST);
            res_now.temp = 9'((tot_t + HIST / 2) / HIST);
        end else begin
            res_now.hum = 10'(h);
            res_now.temp = 9'(t);
        end
    endfunction

    // One tick of the reader: returns the result word that the tick produces.
    function automatic reading_t next_reading(bit ln, bit st);
        int unsigned tries;
        tries = (cfg_val[CFG_TRIES] == 0) ? 1 : cfg_val[CFG_TRIES];
        res_now = '0;
        case (ph)
            PH_IDLE: begin
                if (st) begin
                    tries_done = 0;
                    lastf = FAIL_NONE;
                    begin_try();
                end
            end
            PH_START: begin
                if (tc >= cfg_val[CFG_START]) begin
                    ph = PH_RELEASE;
                    tc = 1;
                end else tc++;
            end
            PH_RELEASE: begin
                if (tc >= cfg_val[CFG_RELEASE]) begin
                    ph = PH_RESP_LOW;
                    tc = 0;
                end else tc++;
            end
            PH_RESP_LOW, PH_RESP_END: begin
                if (!ln) begin
                    ph = (ph == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_LOW;
                    tc = 1;
                end else begin
                    tc++;
                    if (tc > cfg_val[CFG_TIMEOUT]) fail_try(FAIL_NORESP);
                end
            end
            PH_RESP_HIGH: begin
                if (ln) begin
                    ph = PH_RESP_END;
                    tc = 1;
                end else begin
                    tc++;
                    if (tc > cfg_val[CFG_TIMEOUT]) fail_try(FAIL_NORESP);
                end
            end
            PH_BIT_LOW: begin
                if (ln) begin
                    ph = PH_BIT_HIGH;
                    tc = 1;
                end else begin
                    tc++;
                    // A stuck low inside a bit reads as a zero and moves on.
                    if (tc > cfg_val[CFG_TIMEOUT]) begin
                        tc = 0;
                        shift_in(1'b0);
                    end
                end
            end
            PH_BIT_HIGH: begin
                if (!ln) begin
                    ph = PH_BIT_LOW;
                    shift_in(tc > cfg_val[CFG_THRESH]);
                    if (ph == PH_BIT_LOW) tc = 1;
                end else begin
                    tc++;
                    if (tc > cfg_val[CFG_TIMEOUT]) begin
                        ph = PH_BIT_LOW;
                        tc = 0;
                        shift_in(1'b0);
                    end
                end
            end
            PH_GAP: begin
                tc++;
                if (tc >= cfg_val[CFG_GAP]) begin
                    if (tries_done < 7) tries_done++;
                    if (tries_done >= tries) begin
                        ph = PH_IDLE;
                        tc = 0;
                        res_now.done = 1'b1;
                    end else begin_try();
                end
            end
            default: begin
                ph = PH_IDLE;
                tc = 0;
            end
        endcase
        res_now.drive = (ph == PH_START);
        res_now.busy = (ph != PH_IDLE);
        res_now.fail = lastf;
        return res_now;
    endfunction

    // Picks a new frame for the coming attempt: mostly good readings, some
    // with a bad checksum, out of range or plain garbage.
    function automatic void plan_frame();
        logic [7:0] d0, d1, d2, d3, d4;
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            d0 = 8'($urandom_range(0, 99));
            d1 = 8'($urandom_range(0, 9));
            d2 = 8'($urandom_range(0, 60));
            d3 = 8'($urandom_range(0, 9));
        end else begin
            d0 = 8'($urandom);
            d1 = 8'($urandom);
            d2 = 8'($urandom);
            d3 = 8'($urandom);
        end
        d4 = d0 + d1 + d2 + d3;
        if (kind == 14 || kind == 15) d4 = 8'(d4 + $urandom_range(1, 255));
        plan = {d0, d1, d2, d3, d4};
        if (kind >= 18) plan = 40'({$urandom, $urandom});
        resp_fail = ($urandom_range(0, 15) == 0);
        wait_len = $urandom_range(0, 3);
    endfunction

    // Chooses the next tick from where the predictor says the sequence stands,
    // so that most attempts walk the whole frame.
    function automatic void choose_tick(output bit ln, output bit st);
        int unsigned thr;
        bit deliver;
        thr = cfg_val[CFG_THRESH];
        deliver = !resp_fail && tc >= wait_len;
        ln = 1'($urandom_range(0, 1));
        st = 1'($urandom_range(0, 1));
        case (ph)
            PH_IDLE:      st = ($urandom_range(0, 7) != 0);
            PH_START, PH_RELEASE: plan_frame();
            PH_RESP_LOW, PH_RESP_END: ln = !deliver;
            PH_BIT_LOW: begin
                // After a timed-out bit the next low is short again.
                if (tc == 0) lo_len = $urandom_range(0, 2);
                ln = (tc >= lo_len);
            end
            PH_RESP_HIGH: ln = deliver;
            PH_BIT_HIGH: begin
                if (tc == 1) begin
                    if (plan[39 - bidx])
                        hi_len = thr + 1 + $urandom_range(0, 1);
                    else
                        hi_len = $urandom_range(1, thr < 1 ? 1 : (thr < 4 ? thr : 4));
                    if ($urandom_range(0, 39) == 0) hi_len = cfg_val[CFG_TIMEOUT] + 2;
                    lo_len = ($urandom_range(0, 39) == 0) ? cfg_val[CFG_TIMEOUT] + 2
                                                          : $urandom_range(0, 2);
                end
                ln = (tc < hi_len);
            end
            default: ;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: its own pattern of stalls, plus one long hold-off on request.
    initial begin
        int mode, len;
        out_rdy <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(10, 150);
            repeat (len) begin
                @(posedge i_clk);
                if (hold_req) begin
                    out_rdy <= 1'b0;
                    repeat (300) @(posedge i_clk);
                    hold_req = 0;
                end else begin
                    out_rdy <= (mode == 0) ? 1'b1 :
                               (mode == 1) ? ($urandom_range(0, 3) != 0)
                                           : ($urandom_range(0, 2) == 0);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        reading_t want;
        if (i_rst_n && out_vld && out_rdy) begin
            if (readings_due.size() == 0) begin
                $error("result word with no expectation waiting");
                errors++;
            end else begin
                want = readings_due.pop_front();
                n_checked++;
                if (got.drive !== want.drive) begin
                    $error("drive_low exp %0d got %0d", want.drive, got.drive);
                    errors++;
                end
                if (got.busy !== want.busy) begin
                    $error("busy_res exp %0d got %0d", want.busy, got.busy);
                    errors++;
                end
                if (got.done !== want.done) begin
                    $error("done_res exp %0d got %0d", want.done, got.done);
                    errors++;
                end
                if (got.ok !== want.ok) begin
                    $error("read_ok exp %0d got %0d", want.ok, got.ok);
                    errors++;
                end
                if (got.fail !== want.fail) begin
                    $error("fail_reason exp %0d got %0d", want.fail, got.fail);
                    errors++;
                end
                if (got.hum !== want.hum) begin
                    $error("humidity_tenths exp %0d got %0d", want.hum, got.hum);
                    errors++;
                end
                if (got.temp !== want.temp) begin
                    $error("temp_tenths exp %0d got %0d", want.temp, got.temp);
                    errors++;
                end
                if (got.avg !== want.avg) begin
                    $error("averaged exp %0d got %0d", want.avg, got.avg);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_vld && in_rdy) || (out_vld && out_rdy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_tick(bit ln, bit st, bit typed, reading_t want);
        reading_t r;
        if (burst_left == 0) begin
            in_vld <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
        end
        in_vld <= 1'b1;
        line_lvl <= ln;
        start_req <= st;
        @(posedge i_clk);
        while (!in_rdy) @(posedge i_clk);
        r = next_reading(ln, st);
        if (r.done && r.ok) n_good++;
        if (r.done && !r.ok) n_failed++;
        if (r.avg) n_avg++;
        readings_due.push_back(typed ? want : r);
        n_ticks++;
        burst_left--;
    endtask

    // Stops sending until every expected word is back and the pipe is empty.
    task automatic drain();
        in_vld <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apply_set(int k);
        drain();
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= i[2:0];
            cfg_data <= 20'(reg_sets[k][i]);
            @(posedge i_clk);
            cfg_val[i] = reg_sets[k][i] & ((1 << reg_width[i]) - 1);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int target, bit with_pressure);
        bit ln, st;
        int k;
        k = 0;
        while (k < target || ph != PH_IDLE) begin
            choose_tick(ln, st);
            send_tick(ln, st, 1'b0, QUIET);
            k++;
            if (with_pressure && k == 15) hold_req = 1;
            if (with_pressure && k == 45) drain();
        end
    endtask

    step_t script [] = '{
        '{1'b0, 1'b0, 1'b1, QUIET},
        '{1'b1, 1'b0, 1'b1, QUIET},
        // No response at all: the line never goes low.
        '{1'b1, 1'b1, 1'b0, QUIET},
        '{1'b1, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b1, NORESP_DONE},
        // Response low seen, but the response high never comes.
        '{1'b1, 1'b1, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b1, NORESP_DONE},
        // Full response, then the start of the data bits.
        '{1'b1, 1'b1, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET}
    };

    initial begin
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_THRESH;
        cfg_data <= '0;
        in_vld <= 1'b0;
        line_lvl <= 1'b0;
        start_req <= 1'b0;
        errors = 0;
        n_ticks = 0;
        n_good = 0;
        n_failed = 0;
        n_avg = 0;
        n_checked = 0;
        burst_left = 0;
        hold_req = 0;
        quiet_cycles = 0;
        reset_model();
        plan_frame();
        lo_len = 1;
        hi_len = 1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (i == 2) apply_set(0);
            send_tick(script[i].ln, script[i].st, script[i].typed, script[i].want);
        end
        run_random(0, 1'b0);

        for (int k = 1; k < 6; k++) begin
            apply_set(k);
            run_random(60, k == 2);
        end

        drain();
        $display("Covered %0d ticks, %0d words checked, %0d good readings (%0d averaged),",
                 n_ticks, n_checked, n_good, n_avg);
        $display("%0d failed requests, over six register sets with stalls on both sides.",
                 n_failed);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
